FILE: rtl/bisl_pkg.sv
// shared types, codes and constants of the bencode info span locator
package bisl_pkg;

    localparam int BISL_MAX_DEPTH    = 64;
    localparam int BISL_LENGTH_WIDTH = 32;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_TOP    = 3'd1;
    localparam logic [2:0] ST_BAD_KEY   = 3'd2;
    localparam logic [2:0] ST_BAD_BYTE  = 3'd3;
    localparam logic [2:0] ST_NOT_DICT  = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_UNTERM    = 3'd6;
    localparam logic [2:0] ST_OVERFLOW  = 3'd7;

    // bencode marker bytes
    localparam logic [7:0] CH_INT   = 8'h69; // i
    localparam logic [7:0] CH_END   = 8'h65; // e
    localparam logic [7:0] CH_DICT  = 8'h64; // d
    localparam logic [7:0] CH_LIST  = 8'h6c; // l
    localparam logic [7:0] CH_COLON = 8'h3a; // :
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] KEY_LEN = 3'd4;

    typedef enum logic [13:0] {
        PH_TOP        = 14'h0001,
        PH_KEY_START  = 14'h0002,
        PH_KEY_LEN    = 14'h0004,
        PH_KEY_BYTES  = 14'h0008,
        PH_INFO_VALUE = 14'h0010,
        PH_SKIP_ITEM  = 14'h0020,
        PH_SKIP_INT   = 14'h0040,
        PH_SKIP_LEN   = 14'h0080,
        PH_SKIP_STR   = 14'h0100,
        PH_SPAN_ITEM  = 14'h0200,
        PH_SPAN_INT   = 14'h0400,
        PH_SPAN_LEN   = 14'h0800,
        PH_SPAN_STR   = 14'h1000,
        PH_DONE       = 14'h2000
    } t_phase;

    // characters of the wanted key "info"
    function automatic logic [7:0] key_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h69;
            2'd1: c = 8'h6e;
            2'd2: c = 8'h66;
            2'd3: c = 8'h6f;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/bisl_in_if.sv
// input byte channel of the bencode info span locator
interface bisl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/bisl_out_if.sv
// result channel of the bencode info span locator
interface bisl_out_if;
    logic       valid;
    logic       ready;
    logic       in_span;
    logic       span_first;
    logic       span_final;
    logic [2:0] status;
    logic       finished;

    modport source(output valid, output in_span, output span_first, output span_final,
                   output status, output finished, input ready);
    modport sink(input valid, input in_span, input span_first, input span_final,
                 input status, input finished, output ready);
endinterface

FILE: rtl/bisl_len_mac.sv
// decimal length accumulator step: acc * 10 + digit with overflow flag
module bisl_len_mac #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic [LENGTH_WIDTH-1:0] i_acc,
    input  logic [3:0]              i_digit,
    output logic [LENGTH_WIDTH-1:0] o_sum,
    output logic                    o_ovf
);
    logic [LENGTH_WIDTH+3:0] w_ext;
    logic [LENGTH_WIDTH+3:0] w_sum;

    // times ten as shift and add
    assign w_ext = {4'b0000, i_acc};
    assign w_sum = (w_ext << 3) + (w_ext << 1) + {{LENGTH_WIDTH{1'b0}}, i_digit};
    assign o_sum = w_sum[LENGTH_WIDTH-1:0];
    assign o_ovf = |w_sum[LENGTH_WIDTH+3:LENGTH_WIDTH];
endmodule

FILE: rtl/bencode_info_span_locator_core.sv
// top level of the bencode info span locator: scanner, input and result registers
//
//  channel     dir  fields                                             transfer
//  i_byte_ch   in   data_byte[7:0], last_byte                          valid & ready
//  o_span_ch   out  in_span, span_first, span_final, status[2:0],      valid & ready
//                   finished
//
// one byte per cycle sustained while the result side is ready; a result passes through the input
// register and then the result register; the limit is the scan state update, which advances once per byte
// synchronous active-low reset returns the scanner to "expect opening dictionary"
// a stalled result holds the input register; the input accepts again as the result drains
module bencode_info_span_locator_core
    import bisl_pkg::*;
#(
    parameter int MAX_DEPTH    = BISL_MAX_DEPTH,
    parameter int LENGTH_WIDTH = BISL_LENGTH_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bisl_in_if.sink     i_byte_ch,
    bisl_out_if.source  o_span_ch
);
    localparam int DW = $clog2(MAX_DEPTH + 1);

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    // result register
    logic       r_out_valid;
    logic       r_in_span;
    logic       r_span_first;
    logic       r_span_final;
    logic [2:0] r_status;
    logic       r_finished;

    // scan state
    t_phase                  r_phase,    n_phase;
    logic [DW-1:0]           r_depth,    n_depth;
    logic [LENGTH_WIDTH-1:0] r_len,      n_len;
    logic [LENGTH_WIDTH-1:0] r_skip,     n_skip;
    logic [2:0]              r_kidx,     n_kidx;
    logic                    r_kcand,    n_kcand;
    logic [2:0]              r_err,      n_err;
    logic                    r_span_done, n_span_done;

    logic f_inspan, f_first, f_final;

    logic w_adv;
    logic w_in_take;

    // byte classification
    logic w_is_digit;
    logic w_len_start;
    logic [LENGTH_WIDTH-1:0] w_acc_in;
    logic [LENGTH_WIDTH-1:0] w_len_sum;
    logic w_len_ovf;
    logic [LENGTH_WIDTH-1:0] w_skip_dec;
    logic w_key_hit;
    logic w_depth_full;

    // handshake: the result register takes a new item when empty or draining
    assign w_adv     = r_s1_valid && (!r_out_valid || o_span_ch.ready);
    assign i_byte_ch.ready = !r_s1_valid || w_adv;
    assign w_in_take = i_byte_ch.valid && i_byte_ch.ready;

    assign o_span_ch.valid      = r_out_valid;
    assign o_span_ch.in_span    = r_in_span;
    assign o_span_ch.span_first = r_span_first;
    assign o_span_ch.span_final = r_span_final;
    assign o_span_ch.status     = r_status;
    assign o_span_ch.finished   = r_finished;

    assign w_is_digit = (r_s1_byte >= CH_ZERO) && (r_s1_byte <= CH_NINE);

    // a length opened from an item or key start begins from zero
    assign w_len_start = (r_phase == PH_KEY_START) || (r_phase == PH_SKIP_ITEM)
                      || (r_phase == PH_SPAN_ITEM);
    assign w_acc_in    = w_len_start ? '0 : r_len;

    bisl_len_mac #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_len_mac (
        .i_acc   (w_acc_in),
        .i_digit (r_s1_byte[3:0]),
        .o_sum   (w_len_sum),
        .o_ovf   (w_len_ovf)
    );

    assign w_skip_dec   = r_skip - LENGTH_WIDTH'(1);
    assign w_key_hit    = r_kcand && (r_kidx < KEY_LEN) && (r_s1_byte == key_char(r_kidx[1:0]));
    assign w_depth_full = (r_depth >= DW'(MAX_DEPTH));

    always_comb begin
        n_phase     = r_phase;
        n_depth     = r_depth;
        n_len       = r_len;
        n_skip      = r_skip;
        n_kidx      = r_kidx;
        n_kcand     = r_kcand;
        n_err       = r_err;
        n_span_done = r_span_done;
        f_first     = 1'b0;
        f_final     = 1'b0;
        f_inspan    = (r_phase == PH_SPAN_ITEM) || (r_phase == PH_SPAN_INT)
                   || (r_phase == PH_SPAN_LEN) || (r_phase == PH_SPAN_STR);

        unique case (r_phase)
            PH_TOP: begin
                if (r_s1_byte == CH_DICT) begin
                    n_depth = DW'(1);
                    n_phase = PH_KEY_START;
                end else begin
                    n_err   = ST_NO_TOP;
                    n_phase = PH_DONE;
                end
            end
            PH_KEY_START: begin
                if (r_s1_byte == CH_END) begin
                    n_err   = ST_NOT_FOUND;
                    n_phase = PH_DONE;
                end else if (w_is_digit) begin
                    if (w_len_ovf) begin
                        n_err   = ST_OVERFLOW;
                        n_phase = PH_DONE;
                    end else begin
                        n_len   = w_len_sum;
                        n_phase = PH_KEY_LEN;
                    end
                end else begin
                    n_err   = ST_BAD_KEY;
                    n_phase = PH_DONE;
                end
            end
            PH_KEY_LEN: begin
                if (w_is_digit) begin
                    if (w_len_ovf) begin
                        n_err   = ST_OVERFLOW;
                        n_phase = PH_DONE;
                    end else begin
                        n_len = w_len_sum;
                    end
                end else if (r_s1_byte == CH_COLON) begin
                    n_skip  = r_len;
                    n_kcand = (r_len == LENGTH_WIDTH'(KEY_LEN));
                    n_kidx  = '0;
                    n_len   = '0;
                    n_phase = (r_len == '0) ? PH_SKIP_ITEM : PH_KEY_BYTES;
                end else begin
                    n_err   = ST_BAD_BYTE;
                    n_phase = PH_DONE;
                end
            end
            PH_KEY_BYTES: begin
                if (w_key_hit) begin
                    n_kidx = r_kidx + 3'd1;
                end else begin
                    n_kcand = 1'b0;
                end
                n_skip = w_skip_dec;
                if (w_skip_dec == '0) begin
                    n_phase = (n_kcand && (n_kidx == KEY_LEN)) ? PH_INFO_VALUE : PH_SKIP_ITEM;
                end
            end
            PH_INFO_VALUE: begin
                if (r_s1_byte != CH_DICT) begin
                    n_err   = ST_NOT_DICT;
                    n_phase = PH_DONE;
                end else if (w_depth_full) begin
                    n_err   = ST_OVERFLOW;
                    n_phase = PH_DONE;
                end else begin
                    n_depth  = r_depth + DW'(1);
                    n_phase  = PH_SPAN_ITEM;
                    f_first  = 1'b1;
                    f_inspan = 1'b1;
                end
            end
            PH_SKIP_ITEM, PH_SPAN_ITEM: begin
                if (r_s1_byte == CH_INT) begin
                    n_phase = (r_phase == PH_SKIP_ITEM) ? PH_SKIP_INT : PH_SPAN_INT;
                end else if ((r_s1_byte == CH_DICT) || (r_s1_byte == CH_LIST)) begin
                    if (w_depth_full) begin
                        n_err   = ST_OVERFLOW;
                        n_phase = PH_DONE;
                    end else begin
                        n_depth = r_depth + DW'(1);
                    end
                end else if (r_s1_byte == CH_END) begin
                    if (r_depth <= DW'(1)) begin
                        // stray end where a top-level value belongs
                        n_err   = ST_BAD_BYTE;
                        n_phase = PH_DONE;
                    end else begin
                        n_depth = r_depth - DW'(1);
                        if (r_phase == PH_SKIP_ITEM) begin
                            n_phase = (n_depth <= DW'(1)) ? PH_KEY_START : PH_SKIP_ITEM;
                        end else if (n_depth <= DW'(1)) begin
                            f_final     = 1'b1;
                            n_span_done = 1'b1;
                            n_phase     = PH_DONE;
                        end
                    end
                end else if (w_is_digit) begin
                    if (w_len_ovf) begin
                        n_err   = ST_OVERFLOW;
                        n_phase = PH_DONE;
                    end else begin
                        n_len   = w_len_sum;
                        n_phase = (r_phase == PH_SKIP_ITEM) ? PH_SKIP_LEN : PH_SPAN_LEN;
                    end
                end else begin
                    n_err   = ST_BAD_BYTE;
                    n_phase = PH_DONE;
                end
            end
            PH_SKIP_INT: begin
                if (r_s1_byte == CH_END) begin
                    n_phase = (r_depth <= DW'(1)) ? PH_KEY_START : PH_SKIP_ITEM;
                end
            end
            PH_SPAN_INT: begin
                if (r_s1_byte == CH_END) begin
                    n_phase = PH_SPAN_ITEM;
                end
            end
            PH_SKIP_LEN, PH_SPAN_LEN: begin
                if (w_is_digit) begin
                    if (w_len_ovf) begin
                        n_err   = ST_OVERFLOW;
                        n_phase = PH_DONE;
                    end else begin
                        n_len = w_len_sum;
                    end
                end else if (r_s1_byte == CH_COLON) begin
                    n_skip = r_len;
                    n_len  = '0;
                    if (r_len != '0) begin
                        n_phase = (r_phase == PH_SKIP_LEN) ? PH_SKIP_STR : PH_SPAN_STR;
                    end else if (r_phase == PH_SPAN_LEN) begin
                        n_phase = PH_SPAN_ITEM;
                    end else begin
                        n_phase = (r_depth <= DW'(1)) ? PH_KEY_START : PH_SKIP_ITEM;
                    end
                end else begin
                    n_err   = ST_BAD_BYTE;
                    n_phase = PH_DONE;
                end
            end
            PH_SKIP_STR: begin
                n_skip = w_skip_dec;
                if (w_skip_dec == '0) begin
                    n_phase = (r_depth <= DW'(1)) ? PH_KEY_START : PH_SKIP_ITEM;
                end
            end
            PH_SPAN_STR: begin
                n_skip = w_skip_dec;
                if (w_skip_dec == '0) begin
                    n_phase = PH_SPAN_ITEM;
                end
            end
            PH_DONE: begin
                // bytes after the end of the scan are ignored
                f_inspan = 1'b0;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // final byte of the file that leaves the scan open
        if ((r_phase != PH_DONE) && r_s1_last && (n_phase != PH_DONE)) begin
            if ((n_phase == PH_SPAN_ITEM) || (n_phase == PH_SPAN_INT)
                || (n_phase == PH_SPAN_LEN) || (n_phase == PH_SPAN_STR)) begin
                n_err = ST_UNTERM;
            end else begin
                n_err = ST_NOT_FOUND;
            end
            n_phase = PH_DONE;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (w_in_take) begin
            r_s1_byte <= i_byte_ch.data_byte;
            r_s1_last <= i_byte_ch.last_byte;
        end
    end

    // scan state, advanced once per byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TOP;
            r_depth     <= '0;
            r_len       <= '0;
            r_skip      <= '0;
            r_kidx      <= '0;
            r_kcand     <= 1'b0;
            r_err       <= ST_OK;
            r_span_done <= 1'b0;
        end else if (w_adv) begin
            r_phase     <= n_phase;
            r_depth     <= n_depth;
            r_len       <= n_len;
            r_skip      <= n_skip;
            r_kidx      <= n_kidx;
            r_kcand     <= n_kcand;
            r_err       <= n_err;
            r_span_done <= n_span_done;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_span_ch.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_in_span    <= f_inspan;
            r_span_first <= f_first;
            r_span_final <= f_final;
            r_status     <= n_err;
            r_finished   <= (n_phase == PH_DONE);
        end
    end

    // the end of the scan is sticky until reset
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("scanner left the finished phase");

    // a completed span always ends the scan cleanly
    a_span_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_span_done |-> ((r_phase == PH_DONE) && (r_err == ST_OK)))
        else $error("span completed without a clean finish");

    // the closing byte of the span is the finishing, error-free transfer
    a_final_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_span_final) |-> (r_finished && (r_status == ST_OK) && r_in_span))
        else $error("span end reported without finish");

    // nesting never exceeds the configured depth
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_DEPTH))
        else $error("nesting depth beyond limit");

endmodule

FILE: tb/bisl_span_checker.sv
// checker for the bencode info span locator: predicts the tags of each byte and compares results
module bisl_span_checker
    import bisl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bisl_in_if         byte_ch,
    bisl_out_if        span_ch,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results,
    output int         o_span_bytes,
    output logic [2:0] o_last_status
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       in_span;
        logic       span_first;
        logic       span_final;
        logic [2:0] status;
        logic       finished;
    } span_res_t;

    localparam logic [31:0] INFO_KEY = "info";

    // scanner state as the block should hold it
    t_phase      phase_q;
    int unsigned depth_q;
    logic [63:0] len_acc_q;
    logic [63:0] str_left_q;
    int unsigned key_idx_q;
    bit          key_cand_q;
    logic [2:0]  err_q;

    span_res_t   tags_due[$];

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_results     = 0;
        o_span_bytes  = 0;
        o_last_status = ST_OK;
    end

    function automatic bit is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit is_span_phase(t_phase p);
        case (p)
            PH_SPAN_ITEM, PH_SPAN_INT, PH_SPAN_LEN, PH_SPAN_STR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void abort_scan(logic [2:0] code);
        err_q   = code;
        phase_q = PH_DONE;
    endfunction

    function automatic void take_digit(logic [7:0] b);
        logic [63:0] lim;
        logic [63:0] d;
        lim = (64'd1 << BISL_LENGTH_WIDTH) - 64'd1;
        d   = {56'd0, b - CH_ZERO};
        if (len_acc_q > (lim - d) / 64'd10) abort_scan(ST_OVERFLOW);
        else len_acc_q = len_acc_q * 64'd10 + d;
    endfunction

    function automatic void open_level();
        if (depth_q >= BISL_MAX_DEPTH) abort_scan(ST_OVERFLOW);
        else depth_q++;
    endfunction

    // a skipped value is over: back to the next key at top level, else keep skipping
    function automatic void value_skipped();
        if (depth_q <= 1) phase_q = PH_KEY_START;
        else phase_q = PH_SKIP_ITEM;
    endfunction

    function automatic span_res_t scan_byte(logic [7:0] b, logic last);
        span_res_t r;
        t_phase    p;
        bit        skipping;
        p = phase_q;
        r = '0;
        r.in_span = is_span_phase(p);
        skipping  = (p == PH_SKIP_ITEM);
        case (p)
            PH_TOP: begin
                if (b == CH_DICT) begin
                    depth_q = 1;
                    phase_q = PH_KEY_START;
                end else abort_scan(ST_NO_TOP);
            end
            PH_KEY_START: begin
                if (b == CH_END) abort_scan(ST_NOT_FOUND);
                else if (is_digit(b)) begin
                    len_acc_q = '0;
                    take_digit(b);
                    if (phase_q != PH_DONE) phase_q = PH_KEY_LEN;
                end else abort_scan(ST_BAD_KEY);
            end
            PH_KEY_LEN: begin
                if (is_digit(b)) take_digit(b);
                else if (b == CH_COLON) begin
                    str_left_q = len_acc_q;
                    key_cand_q = (len_acc_q == 64'd4);
                    key_idx_q  = 0;
                    len_acc_q  = '0;
                    if (str_left_q == 0) phase_q = PH_SKIP_ITEM;
                    else phase_q = PH_KEY_BYTES;
                end else abort_scan(ST_BAD_BYTE);
            end
            PH_KEY_BYTES: begin
                if (key_cand_q && key_idx_q < 4 && b == INFO_KEY[31 - 8 * key_idx_q -: 8])
                    key_idx_q++;
                else
                    key_cand_q = 1'b0;
                str_left_q--;
                if (str_left_q == 0) begin
                    if (key_cand_q && key_idx_q == 4) phase_q = PH_INFO_VALUE;
                    else phase_q = PH_SKIP_ITEM;
                end
            end
            PH_INFO_VALUE: begin
                if (b == CH_DICT) begin
                    open_level();
                    if (phase_q != PH_DONE) begin
                        phase_q      = PH_SPAN_ITEM;
                        r.span_first = 1'b1;
                        r.in_span    = 1'b1;
                    end
                end else abort_scan(ST_NOT_DICT);
            end
            PH_SKIP_ITEM, PH_SPAN_ITEM: begin
                if (b == CH_INT) begin
                    if (skipping) phase_q = PH_SKIP_INT;
                    else phase_q = PH_SPAN_INT;
                end else if (b == CH_DICT || b == CH_LIST) open_level();
                else if (b == CH_END) begin
                    if (depth_q <= 1) abort_scan(ST_BAD_BYTE);
                    else begin
                        depth_q--;
                        if (skipping) value_skipped();
                        else if (depth_q <= 1) begin
                            r.span_final = 1'b1;
                            phase_q      = PH_DONE;
                        end
                    end
                end else if (is_digit(b)) begin
                    len_acc_q = '0;
                    take_digit(b);
                    if (phase_q != PH_DONE) begin
                        if (skipping) phase_q = PH_SKIP_LEN;
                        else phase_q = PH_SPAN_LEN;
                    end
                end else abort_scan(ST_BAD_BYTE);
            end
            PH_SKIP_INT: begin
                if (b == CH_END) value_skipped();
            end
            PH_SPAN_INT: begin
                if (b == CH_END) phase_q = PH_SPAN_ITEM;
            end
            PH_SKIP_LEN, PH_SPAN_LEN: begin
                if (is_digit(b)) take_digit(b);
                else if (b == CH_COLON) begin
                    str_left_q = len_acc_q;
                    len_acc_q  = '0;
                    if (str_left_q == 0) begin
                        if (p == PH_SKIP_LEN) value_skipped();
                        else phase_q = PH_SPAN_ITEM;
                    end else if (p == PH_SKIP_LEN) phase_q = PH_SKIP_STR;
                    else phase_q = PH_SPAN_STR;
                end else abort_scan(ST_BAD_BYTE);
            end
            PH_SKIP_STR: begin
                str_left_q--;
                if (str_left_q == 0) value_skipped();
            end
            PH_SPAN_STR: begin
                str_left_q--;
                if (str_left_q == 0) phase_q = PH_SPAN_ITEM;
            end
            default: phase_q = PH_DONE;
        endcase

        if (p == PH_DONE) r.in_span = 1'b0;
        else if (last && phase_q != PH_DONE) begin
            if (is_span_phase(phase_q)) abort_scan(ST_UNTERM);
            else abort_scan(ST_NOT_FOUND);
        end
        r.status   = err_q;
        r.finished = (phase_q == PH_DONE);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        span_res_t seen;
        span_res_t due;
        if (!i_rst_n) begin
            phase_q    = PH_TOP;
            depth_q    = 0;
            len_acc_q  = '0;
            str_left_q = '0;
            key_idx_q  = 0;
            key_cand_q = 1'b0;
            err_q      = ST_OK;
            tags_due.delete();
        end else begin
            if (span_ch.valid && span_ch.ready) begin
                seen = '{span_ch.in_span, span_ch.span_first, span_ch.span_final,
                         span_ch.status, span_ch.finished};
                o_results++;
                if (seen.in_span === 1'b1) o_span_bytes++;
                o_last_status = seen.status;
                if (tags_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result %0d: in_span=%b first=%b final=%b status=%0d finished=%b",
                                 o_results, seen.in_span, seen.span_first, seen.span_final,
                                 seen.status, seen.finished);
                end else begin
                    due = tags_due.pop_front();
                    if (seen.in_span !== due.in_span || seen.span_first !== due.span_first ||
                        seen.span_final !== due.span_final || seen.status !== due.status ||
                        seen.finished !== due.finished) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("result %0d mismatch: expected in_span=%b first=%b final=%b status=%0d finished=%b, got in_span=%b first=%b final=%b status=%0d finished=%b",
                                     o_results, due.in_span, due.span_first, due.span_final,
                                     due.status, due.finished, seen.in_span, seen.span_first,
                                     seen.span_final, seen.status, seen.finished);
                    end
                end
            end
            if (byte_ch.valid && byte_ch.ready)
                tags_due.push_back(scan_byte(byte_ch.data_byte, byte_ch.last_byte));
        end
        o_pending = tags_due.size();
    end

endmodule

FILE: tb/tb_bencode_info_span_locator_core.sv
// testbench top of the bencode info span locator: builds one long bencoded file and drives it
module tb_bencode_info_span_locator_core
    import bisl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // generous watchdog
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 16;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AT     = 300;
    localparam int SPAN_FROM   = 700;
    localparam int BODY_BYTES  = 1850;
    localparam int AFTER_BYTES = 30;

    // how the file is brought to an end; only one scan fits in a run as reset comes once
    typedef enum int {
        END_CLEAN,
        END_SPAN_CUT,
        END_SPAN_BAD_BYTE,
        END_SPAN_LEN_CHAR,
        END_SPAN_LEN_OVF,
        END_SPAN_DEPTH_OVF,
        END_SPAN_HUGE_LEN,
        END_NOT_DICT,
        END_BAD_KEY,
        END_NO_INFO,
        END_TOP_CUT,
        END_TOP_STRAY_END,
        END_KEY_LEN_OVF,
        END_COUNT
    } t_ending;

    logic i_clk;
    logic i_rst_n = 1'b0;

    bisl_in_if  in_ch();
    bisl_out_if out_ch();

    int         fail_count;
    int         results_due;
    int         results_seen;
    int         span_bytes;
    logic [2:0] final_status;

    // {last_byte, data_byte} for every byte of the file, trailing bytes included
    logic [8:0] stream_q[$];
    t_ending    ending;
    int         bytes_sent   = 0;
    int         send_idle    = 0;
    int         recv_idle    = 0;
    int         cycle_count  = 0;

    bencode_info_span_locator_core uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (in_ch),
        .o_span_ch (out_ch)
    );

    bisl_span_checker span_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .byte_ch       (in_ch),
        .span_ch       (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (results_due),
        .o_results     (results_seen),
        .o_span_bytes  (span_bytes),
        .o_last_status (final_status)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // synchronous reset, held at the start only
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, results_due);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // file building blocks
    // ------------------------------------------------------------------
    function automatic void put_byte(logic [7:0] b, logic last = 1'b0);
        stream_q.push_back({last, b});
    endfunction

    // text with last_byte optionally on its final character
    function automatic void put_text(string s, logic last = 1'b0);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], last && (i == s.len() - 1));
    endfunction

    // length prefix, sometimes with leading zeros, which the scanner must accept
    function automatic void put_len(int unsigned n);
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 3)) put_byte(CH_ZERO);
        put_text($sformatf("%0d:", n));
    endfunction

    // string of arbitrary bytes, every byte value possible
    function automatic void put_string(int unsigned n);
        put_len(n);
        repeat (n) put_byte(8'($urandom_range(255)));
    endfunction

    // integer bodies are not checked, so anything but the closing 'e' goes in
    function automatic void put_int();
        logic [7:0] b;
        put_byte(CH_INT);
        repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(255));
            if (b == CH_END) b = CH_ZERO;
            put_byte(b);
        end
        put_byte(CH_END);
    endfunction

    // one well-formed value: a scalar, or containers nested up to max_nest deep
    function automatic void put_value(int max_nest, int budget);
        int open_cnt;
        int start_at;
        open_cnt = 0;
        start_at = stream_q.size();
        do begin
            if (open_cnt > 0 &&
                (stream_q.size() - start_at > budget || $urandom_range(3) == 0)) begin
                put_byte(CH_END);
                open_cnt--;
            end else begin
                case ($urandom_range(3))
                    0: put_int();
                    1: put_string(($urandom_range(7) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(0, 12));
                    default: begin
                        if (open_cnt < max_nest) begin
                            put_byte($urandom_range(1) ? CH_DICT : CH_LIST);
                            open_cnt++;
                        end else put_int();
                    end
                endcase
            end
        end while (open_cnt > 0);
    endfunction

    // a top-level key that is never "info": near misses, empty and random keys
    function automatic void put_key();
        int unsigned n;
        case ($urandom_range(7))
            0: begin
                put_len(4);
                case ($urandom_range(3))
                    0: put_text("infx");
                    1: put_text("Info");
                    2: put_text("xnfo");
                    default: put_text("inf0");
                endcase
            end
            1: begin
                put_len(5);
                put_text("infoo");
            end
            2: begin
                put_len(3);
                put_text("inf");
            end
            3: put_len(0);
            default: begin
                n = $urandom_range(1, 8);
                put_string(n);
            end
        endcase
    endfunction

    // a byte that cannot start an item, a length or a key
    function automatic logic [7:0] non_item_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON || b == CH_INT ||
               b == CH_DICT || b == CH_LIST || b == CH_END);
        return b;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls plus one long hold-off to back up the block
    // ------------------------------------------------------------------
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && bytes_sent >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus: build the whole file, then transfer it byte by byte
    // ------------------------------------------------------------------
    initial begin
        logic       fault_last;
        logic [7:0] b;
        string      ovf_text;
        string      max_text;
        int         n_items;

        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.last_byte <= 1'b0;

        ovf_text   = $sformatf("%0d", 64'd1 << BISL_LENGTH_WIDTH);
        max_text   = $sformatf("%0d", (64'd1 << BISL_LENGTH_WIDTH) - 64'd1);
        fault_last = 1'($urandom_range(1));
        if ($urandom_range(2) == 0) ending = END_CLEAN;
        else ending = t_ending'($urandom_range(0, END_COUNT - 1));

        // directed opening: empty key, odd integer body, near-miss key with an empty
        // string behind a leading zero, bytes 00 and ff inside an integer
        put_byte(CH_DICT);
        put_text("0:i-e");
        put_text("4:infx00:");
        put_text("3:inf");
        put_byte(CH_INT);
        put_byte(8'h00);
        put_byte(8'hff);
        put_text("dl:");
        put_byte(CH_END);

        // a list nested right up to the depth limit, top dictionary included
        put_text("1:z");
        repeat (BISL_MAX_DEPTH - 1) put_byte(CH_LIST);
        repeat (BISL_MAX_DEPTH - 1) put_byte(CH_END);

        // skipped key/value pairs ahead of the info key
        while (stream_q.size() < ((ending < END_NOT_DICT) ? SPAN_FROM : BODY_BYTES)) begin
            put_key();
            put_value($urandom_range(0, 8), $urandom_range(4, 60));
        end

        if (ending < END_NOT_DICT) begin
            // the info dictionary itself, with one excursion to full depth
            put_len(4);
            put_text("info");
            put_byte(CH_DICT);
            repeat (BISL_MAX_DEPTH - 2) put_byte(CH_DICT);
            repeat (BISL_MAX_DEPTH - 2) put_byte(CH_END);
            while (stream_q.size() < BODY_BYTES)
                put_value($urandom_range(0, 8), $urandom_range(4, 60));
        end

        // the closing bytes; an error may land on the marked last byte, and wins then
        case (ending)
            END_CLEAN:          put_byte(CH_END, 1'($urandom_range(1)));
            END_SPAN_CUT:       put_text("i42", 1'b1);
            END_SPAN_BAD_BYTE:  put_byte(non_item_byte(), fault_last);
            END_SPAN_LEN_CHAR: begin
                put_text("12");
                put_byte(non_item_byte(), fault_last);
            end
            END_SPAN_LEN_OVF:   put_text(ovf_text, fault_last);
            END_SPAN_DEPTH_OVF: begin
                repeat (BISL_MAX_DEPTH - 2) put_byte(CH_LIST);
                put_byte(CH_DICT, fault_last);
            end
            END_SPAN_HUGE_LEN: begin
                // largest accepted length, cut short by the last byte
                put_text({max_text, ":"});
                repeat (4) put_byte(8'($urandom_range(255)));
                put_byte(8'($urandom_range(255)), 1'b1);
            end
            END_NOT_DICT: begin
                put_len(4);
                put_text("info");
                case ($urandom_range(3))
                    0: b = CH_INT;
                    1: b = CH_LIST;
                    2: b = CH_ZERO;
                    default: b = non_item_byte();
                endcase
                put_byte(b, fault_last);
            end
            END_BAD_KEY: begin
                case ($urandom_range(3))
                    0: b = CH_DICT;
                    1: b = CH_INT;
                    2: b = CH_COLON;
                    default: b = non_item_byte();
                endcase
                put_byte(b, fault_last);
            end
            END_NO_INFO:        put_byte(CH_END, fault_last);
            END_TOP_CUT: begin
                put_key();
                put_text("i77", 1'b1);
            end
            END_TOP_STRAY_END: begin
                // an 'e' where a top-level value belongs
                put_key();
                put_byte(CH_END, fault_last);
            end
            default:            put_text(ovf_text, fault_last);
        endcase

        // bytes after the scan has finished, which must be ignored
        repeat (AFTER_BYTES) put_byte(8'($urandom_range(255)), 1'($urandom_range(1)));

        n_items = stream_q.size();

        do @(posedge i_clk); while (!i_rst_n);

        for (int i = 0; i < n_items; i++) begin
            // idling: sender light and receiver heavy, then swapped, then none
            if (i < n_items / 3) begin
                send_idle = 30;
                recv_idle = 57;
            end else if (i < 2 * n_items / 3) begin
                send_idle = 57;
                recv_idle = 30;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            while ($urandom_range(99) < send_idle) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            in_ch.valid     <= 1'b1;
            in_ch.data_byte <= stream_q[i][7:0];
            in_ch.last_byte <= stream_q[i][8];
            // hold the byte until its transfer
            do @(posedge i_clk); while (!in_ch.ready);
            bytes_sent++;
        end
        in_ch.valid <= 1'b0;

        // drain: every expectation met, then a short tail to catch strays
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("scanned a %0d-byte bencoded file closed by %s: %0d results checked, %0d in the info span",
                 n_items, ending.name(), results_seen, span_bytes);
        $display("final status %0d after sender gaps, receiver stalls, a %0d-cycle hold-off and %0d ignored trailing bytes",
                 final_status, HOLD_CYCLES, AFTER_BYTES);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: bencode_info_span_locator_core.f
rtl/bisl_pkg.sv
rtl/bisl_in_if.sv
rtl/bisl_out_if.sv
rtl/bisl_len_mac.sv
rtl/bencode_info_span_locator_core.sv
tb/bisl_span_checker.sv
tb/tb_bencode_info_span_locator_core.sv
